[rtl/core/assert_macros.svh]
// Assertion macros for the blit address generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge out of reset.
`define BAG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define BAG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`else

`define BAG_ASSERT(lbl, prop, msg)

`define BAG_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[rtl/core/bag_pkg.sv]
// Shared types and constants of the blit address generator.
package bag_pkg;

	localparam int SIZE_BITS       = 13;
	localparam int COORD_BITS_DEF  = 12;
	localparam int ADDR_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index as seen on the word-aligned APB address
	localparam logic REG_LINE_WIDTH = 1'b0;

	localparam logic [SIZE_BITS-1:0] LINE_WIDTH_RESET = 13'd640;

	// classification of one queued command word
	typedef struct packed {
		logic is_step;
		logic scaled;
		logic rows_desc;
		logic cols_desc;
		logic nonempty;
	} cmd_flags_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] q_w;
		logic [SIZE_BITS-1:0] r_w;
		logic [SIZE_BITS-1:0] q_h;
		logic [SIZE_BITS-1:0] r_h;
	} div_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// queued word: flags, corners, source size, walked size
	function automatic int cmd_bits(int cb);
		return $bits(cmd_flags_t) + 4 * cb + 4 * SIZE_BITS;
	endfunction

endpackage

[rtl/core/blit_address_generator.sv]
// Top level of the blit address generator: APB register, front end, queue, divider, walker.

// A start word (action 0) loads a rectangle copy command and yields no output; each step
// word (action 1) then yields one source/destination word address pair, with last on the
// final pair and out_of_range when either address wrapped past 2^ADDR_BITS. Steps sent
// while no command runs are dropped; a start during a running command replaces it; an
// empty rectangle yields nothing. Once a command is loaded, pairs stream at one per clock
// while step words keep arriving and the output is not stalled: the walker updates its
// row/column counters and the nearest-neighbor source offsets by quotient/remainder
// accumulation, one row multiply per address, so no per-pixel divide. A scaled start runs
// the shared restoring divider (source size over destination size, both axes at once, one
// quotient bit a cycle), so the steps behind it wait in the queue until it is done. A step
// leaving the queue passes a multiply stage, then add/wrap into the output register;
// the queue (QUEUE_DEPTH words) lets input keep flowing while output is stalled.
// line_width (register 0, reset 640) is the row stride; change it only while idle.
module blit_address_generator import bag_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic                  scaled,
	input  logic [COORD_BITS-1:0] src_x,
	input  logic [COORD_BITS-1:0] src_y,
	input  logic [COORD_BITS-1:0] dst_x,
	input  logic [COORD_BITS-1:0] dst_y,
	input  logic [SIZE_BITS-1:0]  src_w,
	input  logic [SIZE_BITS-1:0]  src_h,
	input  logic [SIZE_BITS-1:0]  dst_w,
	input  logic [SIZE_BITS-1:0]  dst_h,
	// output words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_BITS-1:0]  src_addr,
	output logic [ADDR_BITS-1:0]  dst_addr,
	output logic                  last,
	output logic                  out_of_range
);

	localparam int CMD_W = cmd_bits(COORD_BITS);

	logic [SIZE_BITS-1:0] line_width_q;
	logic                 reg_sel;

	logic             q_full, q_push, q_pop, q_valid;
	logic [CMD_W-1:0] q_wdata, q_rdata;

	logic                 div_go;
	logic [SIZE_BITS-1:0] div_num_w, div_den_w, div_num_h, div_den_h;
	div_res_t             div_res;
	div_stat_t            div_stat;

	// word-aligned decode; byte offset bits are ignored
	assign reg_sel = paddr[APB_ADDR_W-1] == REG_LINE_WIDTH;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(line_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			line_width_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	bag_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.scaled   (scaled),
		.src_x    (src_x),
		.src_y    (src_y),
		.dst_x    (dst_x),
		.dst_y    (dst_y),
		.src_w    (src_w),
		.src_h    (src_h),
		.dst_w    (dst_w),
		.dst_h    (dst_h),
		.full     (q_full),
		.push     (q_push),
		.cmd      (q_wdata)
	);

	bag_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	bag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num_w  (div_num_w),
		.den_w  (div_den_w),
		.num_h  (div_num_h),
		.den_h  (div_den_h),
		.res    (div_res),
		.stat   (div_stat)
	);

	bag_back #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_width   (line_width_q),
		.head_valid   (q_valid),
		.cmd          (q_rdata),
		.pop          (q_pop),
		.div_go       (div_go),
		.div_num_w    (div_num_w),
		.div_den_w    (div_den_w),
		.div_num_h    (div_num_h),
		.div_den_h    (div_den_h),
		.div_res      (div_res),
		.div_stat     (div_stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.last         (last),
		.out_of_range (out_of_range)
	);

endmodule

[rtl/core/bag_front.sv]
// Front end: accepts input words, classifies them and pushes commands to the queue.
module bag_front import bag_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic                              scaled,
	input  logic [COORD_BITS-1:0]             src_x,
	input  logic [COORD_BITS-1:0]             src_y,
	input  logic [COORD_BITS-1:0]             dst_x,
	input  logic [COORD_BITS-1:0]             dst_y,
	input  logic [SIZE_BITS-1:0]              src_w,
	input  logic [SIZE_BITS-1:0]              src_h,
	input  logic [SIZE_BITS-1:0]              dst_w,
	input  logic [SIZE_BITS-1:0]              dst_h,
	input  logic                              full,
	output logic                              push,
	output logic [cmd_bits(COORD_BITS)-1:0]   cmd
);

	cmd_flags_t           flags;
	logic [SIZE_BITS-1:0] walk_w;
	logic [SIZE_BITS-1:0] walk_h;
	logic                 rows_desc;

	// scaled copies walk the destination rectangle, block copies the source one
	assign walk_w    = scaled ? dst_w : src_w;
	assign walk_h    = scaled ? dst_h : src_h;
	assign rows_desc = dst_y > src_y;

	always_comb begin
		flags.is_step   = action;
		flags.scaled    = scaled;
		flags.rows_desc = rows_desc;
		// memmove rule for block copies: right-to-left only on the same row, moving right; scaled copies follow the rows
		flags.cols_desc = scaled ? rows_desc : ((dst_y == src_y) && (dst_x > src_x));
		flags.nonempty  = (walk_w != '0) && (walk_h != '0);
	end

	assign in_ready = !full;
	assign push     = in_valid && !full;
	assign cmd      = {flags, src_x, src_y, dst_x, dst_y, src_w, src_h, walk_w, walk_h};

endmodule

[rtl/core/bag_fifo.sv]
// Small command queue between front end and walker, show-ahead read.
module bag_fifo import bag_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign valid = count_q != '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/bag_div.sv]
// Restoring divider pair: source size over walked size, both axes, one bit a cycle.
module bag_div import bag_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SIZE_BITS-1:0] num_w,
	input  logic [SIZE_BITS-1:0] den_w,
	input  logic [SIZE_BITS-1:0] num_h,
	input  logic [SIZE_BITS-1:0] den_h,
	output div_res_t             res,
	output div_stat_t            stat
);

	localparam int SB    = SIZE_BITS;
	localparam int CNT_W = $clog2(SB);

	typedef struct packed {
		logic [SB-1:0] r;
		logic [SB-1:0] q;
	} div_st_t;

	function automatic div_st_t div_step(input div_st_t s, input logic [SB-1:0] den);
		logic [SB:0]   sh;
		logic [SB+1:0] diff;
		div_st_t       n;
		sh   = {s.r, s.q[SB-1]};
		diff = {1'b0, sh} - {2'b00, den};
		if (!diff[SB+1]) begin
			n.r = diff[SB-1:0];
			n.q = {s.q[SB-2:0], 1'b1};
		end else begin
			n.r = sh[SB-1:0];
			n.q = {s.q[SB-2:0], 1'b0};
		end
		return n;
	endfunction

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	div_st_t          st_w_q;
	div_st_t          st_h_q;
	logic [SB-1:0]    den_w_q;
	logic [SB-1:0]    den_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_w_q  <= '{r: '0, q: num_w};
			st_h_q  <= '{r: '0, q: num_h};
			den_w_q <= den_w;
			den_h_q <= den_h;
		end else if (busy_q) begin
			st_w_q <= div_step(st_w_q, den_w_q);
			st_h_q <= div_step(st_h_q, den_h_q);
		end
	end

	assign res.q_w  = st_w_q.q;
	assign res.r_w  = st_w_q.r;
	assign res.q_h  = st_h_q.q;
	assign res.r_h  = st_h_q.r;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/core/bag_back.sv]
// Back end: rectangle walker with incremental scaling and the address pipeline.
`include "assert_macros.svh"

module bag_back import bag_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [SIZE_BITS-1:0]            line_width,
	input  logic                            head_valid,
	input  logic [cmd_bits(COORD_BITS)-1:0] cmd,
	output logic                            pop,
	output logic                            div_go,
	output logic [SIZE_BITS-1:0]            div_num_w,
	output logic [SIZE_BITS-1:0]            div_den_w,
	output logic [SIZE_BITS-1:0]            div_num_h,
	output logic [SIZE_BITS-1:0]            div_den_h,
	input  div_res_t                        div_res,
	input  div_stat_t                       div_stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ADDR_BITS-1:0]            src_addr,
	output logic [ADDR_BITS-1:0]            dst_addr,
	output logic                            last,
	output logic                            out_of_range
);

	localparam int SB     = SIZE_BITS;
	localparam int CB     = COORD_BITS;
	localparam int ROW_W  = ((CB > SB) ? CB : SB) + 1;
	localparam int PROD_W = ROW_W + SB;
	localparam int FULL_W = (PROD_W + 1 > ADDR_BITS + 1) ? PROD_W + 1 : ADDR_BITS + 1;

	// quotient and remainder of offset * source size over walked size
	typedef struct packed {
		logic [SB-1:0] q;
		logic [SB-1:0] r;
	} acc_t;

	function automatic acc_t acc_up(input acc_t a, input acc_t inc, input logic [SB-1:0] size);
		logic [SB:0] s;
		acc_t        n;
		s = {1'b0, a.r} + {1'b0, inc.r};
		if (s >= {1'b0, size}) begin
			n.r = SB'(s - {1'b0, size});
			n.q = a.q + inc.q + SB'(1);
		end else begin
			n.r = s[SB-1:0];
			n.q = a.q + inc.q;
		end
		return n;
	endfunction

	function automatic acc_t acc_dn(input acc_t a, input acc_t inc, input logic [SB-1:0] size);
		logic [SB:0] t;
		acc_t        n;
		t = {1'b0, a.r} - {1'b0, inc.r};
		if (t[SB]) begin
			n.r = SB'(t + {1'b0, size});
			n.q = a.q - inc.q - SB'(1);
		end else begin
			n.r = t[SB-1:0];
			n.q = a.q - inc.q;
		end
		return n;
	endfunction

	// start value: zero, or at the far end, offset size-1: (size-1)*src = size*src - src
	function automatic acc_t acc_init(input logic desc, input logic [SB-1:0] src,
			input acc_t inc, input logic [SB-1:0] size);
		acc_t n;
		n = '0;
		if (desc) begin
			if (inc.r != '0) begin
				n.q = src - inc.q - SB'(1);
				n.r = size - inc.r;
			end else begin
				n.q = src - inc.q;
			end
		end
		return n;
	endfunction

	cmd_flags_t    c_flags;
	logic [CB-1:0] c_src_x, c_src_y, c_dst_x, c_dst_y;
	logic [SB-1:0] c_src_w, c_src_h, c_walk_w, c_walk_h;

	assign {c_flags, c_src_x, c_src_y, c_dst_x, c_dst_y,
		c_src_w, c_src_h, c_walk_w, c_walk_h} = cmd;

	// command state
	logic          busy_q, div_wait_q;
	logic          scaled_q, rows_desc_q, cols_desc_q;
	logic [CB-1:0] src_x_q, src_y_q, dst_x_q, dst_y_q;
	logic [SB-1:0] src_w_q, src_h_q, w_q, h_q;
	logic [SB-1:0] cur_row_q, cur_col_q;
	acc_t          qr_q, qc_q, qc0_q, inc_r_q, inc_c_q;

	// pipeline
	logic              valid_s1, last_s1;
	logic [PROD_W-1:0] src_prod_s1, dst_prod_s1;
	logic [ROW_W-1:0]  src_col_s1, dst_col_s1;
	logic              out_valid_q, last_q, oor_q;
	logic [ADDR_BITS-1:0] src_addr_q, dst_addr_q;

	logic          adv, start_pop, emit, ld;
	logic          col_end, row_end;
	acc_t          ld_inc_r, ld_inc_c, init_r, init_c, nxt_r, nxt_c;
	logic [SB-1:0] ld_w, ld_h, ld_src_w, ld_src_h;
	logic          ld_rdesc, ld_cdesc;

	logic [ROW_W-1:0]  src_row, src_col, dst_row, dst_col;
	logic [PROD_W-1:0] src_prod, dst_prod;
	logic [FULL_W-1:0] src_full, dst_full;

	assign adv       = !out_valid_q || out_ready;
	assign pop       = head_valid && !div_wait_q && adv;
	assign start_pop = pop && !c_flags.is_step;
	assign emit      = pop && c_flags.is_step && busy_q;
	assign div_go    = start_pop && c_flags.scaled && c_flags.nonempty;
	assign div_num_w = c_src_w;
	assign div_den_w = c_walk_w;
	assign div_num_h = c_src_h;
	assign div_den_h = c_walk_h;

	// block copies step one source word per word walked, no divide needed
	assign ld       = (start_pop && !c_flags.scaled) || div_stat.done;
	assign ld_inc_r = div_stat.done ? '{q: div_res.q_h, r: div_res.r_h} : '{q: SB'(1), r: '0};
	assign ld_inc_c = div_stat.done ? '{q: div_res.q_w, r: div_res.r_w} : '{q: SB'(1), r: '0};
	assign ld_w     = div_stat.done ? w_q : c_walk_w;
	assign ld_h     = div_stat.done ? h_q : c_walk_h;
	assign ld_src_w = div_stat.done ? src_w_q : c_src_w;
	assign ld_src_h = div_stat.done ? src_h_q : c_src_h;
	assign ld_rdesc = div_stat.done ? rows_desc_q : c_flags.rows_desc;
	assign ld_cdesc = div_stat.done ? cols_desc_q : c_flags.cols_desc;
	assign init_r   = acc_init(ld_rdesc, ld_src_h, ld_inc_r, ld_h);
	assign init_c   = acc_init(ld_cdesc, ld_src_w, ld_inc_c, ld_w);

	assign col_end = cols_desc_q ? (cur_col_q == '0) : (cur_col_q >= w_q - SB'(1));
	assign row_end = rows_desc_q ? (cur_row_q == '0) : (cur_row_q >= h_q - SB'(1));
	assign nxt_c   = cols_desc_q ? acc_dn(qc_q, inc_c_q, w_q) : acc_up(qc_q, inc_c_q, w_q);
	assign nxt_r   = rows_desc_q ? acc_dn(qr_q, inc_r_q, h_q) : acc_up(qr_q, inc_r_q, h_q);

	assign src_row  = ROW_W'(src_y_q) + ROW_W'(qr_q.q);
	assign src_col  = ROW_W'(src_x_q) + ROW_W'(qc_q.q);
	assign dst_row  = ROW_W'(dst_y_q) + ROW_W'(cur_row_q);
	assign dst_col  = ROW_W'(dst_x_q) + ROW_W'(cur_col_q);
	assign src_prod = src_row * line_width;
	assign dst_prod = dst_row * line_width;

	assign src_full = FULL_W'(src_prod_s1) + FULL_W'(src_col_s1);
	assign dst_full = FULL_W'(dst_prod_s1) + FULL_W'(dst_col_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			div_wait_q  <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_pop) begin
				busy_q <= c_flags.nonempty;
			end else if (emit && col_end && row_end) begin
				busy_q <= 1'b0;
			end
			if (div_go) begin
				div_wait_q <= 1'b1;
			end else if (div_stat.done) begin
				div_wait_q <= 1'b0;
			end
			if (adv) begin
				valid_s1    <= emit;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_pop) begin
			scaled_q    <= c_flags.scaled;
			rows_desc_q <= c_flags.rows_desc;
			cols_desc_q <= c_flags.cols_desc;
			src_x_q     <= c_src_x;
			src_y_q     <= c_src_y;
			dst_x_q     <= c_dst_x;
			dst_y_q     <= c_dst_y;
			src_w_q     <= c_src_w;
			src_h_q     <= c_src_h;
			w_q         <= c_walk_w;
			h_q         <= c_walk_h;
			cur_row_q   <= (c_flags.nonempty && c_flags.rows_desc) ? c_walk_h - SB'(1) : '0;
			cur_col_q   <= (c_flags.nonempty && c_flags.cols_desc) ? c_walk_w - SB'(1) : '0;
		end
		if (ld) begin
			inc_r_q <= ld_inc_r;
			inc_c_q <= ld_inc_c;
			qr_q    <= init_r;
			qc_q    <= init_c;
			qc0_q   <= init_c;
		end
		if (emit) begin
			if (!col_end) begin
				cur_col_q <= cols_desc_q ? cur_col_q - SB'(1) : cur_col_q + SB'(1);
				qc_q      <= nxt_c;
			end else if (!row_end) begin
				cur_col_q <= cols_desc_q ? w_q - SB'(1) : '0;
				qc_q      <= qc0_q;
				cur_row_q <= rows_desc_q ? cur_row_q - SB'(1) : cur_row_q + SB'(1);
				qr_q      <= nxt_r;
			end
		end
		if (adv && emit) begin
			src_prod_s1 <= src_prod;
			dst_prod_s1 <= dst_prod;
			src_col_s1  <= src_col;
			dst_col_s1  <= dst_col;
			last_s1     <= col_end && row_end;
		end
		if (adv && valid_s1) begin
			src_addr_q <= src_full[ADDR_BITS-1:0];
			dst_addr_q <= dst_full[ADDR_BITS-1:0];
			last_q     <= last_s1;
			oor_q      <= (src_full[FULL_W-1:ADDR_BITS] != '0) ||
				(dst_full[FULL_W-1:ADDR_BITS] != '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign src_addr     = src_addr_q;
	assign dst_addr     = dst_addr_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

	`BAG_ASSERT(a_div_done_waited, div_stat.done |-> div_wait_q, "divider done while not waited for")
	`BAG_ASSERT(a_div_tracked, div_wait_q |-> (div_stat.busy || div_stat.done), "walker waits on an idle divider")
	`BAG_ASSERT_NEXT(a_last_idles, emit && col_end && row_end, !busy_q, "walker still busy after last pair")
	`BAG_ASSERT(a_block_tracks, (busy_q && !scaled_q) |-> ((qr_q.q == cur_row_q) && (qc_q.q == cur_col_q)), "block source offset drifted")
	`BAG_ASSERT(a_rem_bound, (busy_q && !div_wait_q) |-> ((qr_q.r < h_q) && (qc_q.r < w_q)), "scaling remainder out of range")

endmodule
